FILE: rtl/efs_pkg.sv
// ----------------------------------------------------------------------------
// efs_pkg
// Shared types and constants of the earliest free server scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package efs_pkg;

    localparam int SERVERS_DEF = 32;

    localparam int CFG_W  = 6;
    localparam int DUR_W  = 17;
    localparam int JOB_W  = 20;
    localparam int TIME_W = 40;
    localparam int SRV_W  = 6;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    localparam logic KIND_DEPART  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [DUR_W-1:0] duration;
        logic             final_job;
    } job_t;

    typedef struct packed {
        logic              kind;
        logic [JOB_W-1:0]  job_number;
        logic [TIME_W-1:0] total_duration;
        logic [SRV_W-1:0]  latest_server;
        logic              end_of_run;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_DSCAN,
        ST_DEMIT,
        ST_SUMMARY
    } state_t;

    typedef struct packed {
        logic accept;
        logic fill;
        logic scan_start;
        logic place;
        logic mark_done;
        logic emit_dep;
        logic emit_sum;
        logic end_of_run;
        logic clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic has_room;
        logic scan_done;
        logic out_free;
        logic drain_last;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/efs_ram.sv
// ----------------------------------------------------------------------------
// efs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module efs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/efs_ctrl.sv
// ----------------------------------------------------------------------------
// efs_ctrl
// Sequencer: accept, earliest finish scan, placement, drain and summary.
// ----------------------------------------------------------------------------
`default_nettype none

module efs_ctrl
    import efs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       final_job,
    output logic            in_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    last_next = final_job;
                    if (!status.has_room)
                        state_next = ST_SCAN;
                    else if (final_job)
                        state_next = ST_DSCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                    state_next = ST_PLACE;
            end
            ST_PLACE:
            begin
                if (status.out_free)
                    state_next = last_reg ? ST_DSCAN : ST_IDLE;
            end
            ST_DSCAN:
            begin
                if (status.scan_done)
                    state_next = ST_DEMIT;
            end
            ST_DEMIT:
            begin
                if (status.out_free)
                    state_next = status.drain_last ? ST_SUMMARY : ST_DSCAN;
            end
            ST_SUMMARY:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.has_room)
                    begin
                        cmd.fill       = 1'b1;
                        cmd.scan_start = final_job;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                    end
                end
            end
            ST_PLACE:
            begin
                if (status.out_free)
                begin
                    cmd.emit_dep   = 1'b1;
                    cmd.place      = 1'b1;
                    cmd.end_of_run = !last_reg;
                    cmd.scan_start = last_reg;
                end
            end
            ST_DEMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_dep   = 1'b1;
                    cmd.mark_done  = 1'b1;
                    cmd.scan_start = !status.drain_last;
                end
            end
            ST_SUMMARY:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sum   = 1'b1;
                    cmd.end_of_run = 1'b1;
                    cmd.clear      = 1'b1;
                end
            end
            ST_SCAN, ST_DSCAN: ;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/efs_dp.sv
// ----------------------------------------------------------------------------
// efs_dp
// Datapath: server tables, sequential earliest/latest scan, counters and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module efs_dp
    import efs_pkg::*;
#(
    parameter int SERVERS = SERVERS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire job_t             in_data,
    input  wire ctrl_cmd_t        cmd,
    output dp_status_t            status,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output result_t               out_data
);

    localparam int CW = $clog2(SERVERS + 1);
    localparam int AW = (SERVERS > 1) ? $clog2(SERVERS) : 1;
    localparam logic [CFG_W-1:0] SRV_CFG = CFG_W'(SERVERS);

    logic [CFG_W-1:0]  servers_reg;
    logic [CW-1:0]     n_eff;

    logic [CW-1:0]     filled_reg, filled_next;
    logic [CW-1:0]     drain_cnt_reg, drain_cnt_next;
    logic [JOB_W-1:0]  arrivals_reg, arrivals_next;
    logic [TIME_W-1:0] total_reg, total_next;
    logic [DUR_W-1:0]  dur_reg;
    logic [SERVERS-1:0] done_reg, done_next;

    logic              scan_active_reg, scan_active_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic              pend_vld_reg, pend_vld_next;
    logic [AW-1:0]     pend_addr_reg;
    logic              rd_go;

    logic              best_found_reg, best_found_next;
    logic [TIME_W-1:0] best_ft_reg;
    logic [JOB_W-1:0]  best_occ_reg;
    logic [AW-1:0]     best_idx_reg;
    logic              max_found_reg, max_found_next;
    logic [TIME_W-1:0] max_ft_reg;
    logic [AW-1:0]     max_idx_reg;
    logic              take_best, take_max;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [TIME_W-1:0] ft_wdata, ft_rdata;
    logic [JOB_W-1:0]  occ_wdata, occ_rdata;

    logic              out_valid_reg;
    result_t           out_data_reg;
    logic              out_free;

    always_comb
    begin
        if (servers_reg == '0)
            n_eff = CW'(1);
        else if (servers_reg > SRV_CFG)
            n_eff = CW'(SERVERS);
        else
            n_eff = servers_reg[CW-1:0];
    end

    assign out_free = !out_valid_reg || out_ready;
    assign rd_go    = scan_active_reg && (rd_idx_reg < filled_reg);

    assign status.has_room   = filled_reg < n_eff;
    assign status.scan_done  = !scan_active_reg && !pend_vld_reg;
    assign status.out_free   = out_free;
    assign status.drain_last = (drain_cnt_reg + CW'(1)) == filled_reg;

    assign wr_en     = cmd.fill || cmd.place;
    assign wr_addr   = cmd.fill ? filled_reg[AW-1:0] : best_idx_reg;
    assign ft_wdata  = cmd.fill ? TIME_W'(in_data.duration)
                                : best_ft_reg + TIME_W'(dur_reg);
    assign occ_wdata = cmd.fill ? arrivals_reg + JOB_W'(1) : arrivals_reg;

    efs_ram #(
        .WIDTH (TIME_W),
        .DEPTH (SERVERS)
    ) u_ft_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (ft_wdata),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ft_rdata)
    );

    efs_ram #(
        .WIDTH (JOB_W),
        .DEPTH (SERVERS)
    ) u_occ_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (occ_wdata),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (occ_rdata)
    );

    assign take_best = pend_vld_reg && !done_reg[pend_addr_reg]
                       && (!best_found_reg || ft_rdata < best_ft_reg);
    assign take_max  = pend_vld_reg && (!max_found_reg || ft_rdata >= max_ft_reg);

    always_comb
    begin
        filled_next      = filled_reg;
        drain_cnt_next   = drain_cnt_reg;
        arrivals_next    = arrivals_reg;
        total_next       = total_reg;
        done_next        = done_reg;
        scan_active_next = scan_active_reg;
        rd_idx_next      = rd_idx_reg;
        pend_vld_next    = rd_go;
        best_found_next  = best_found_reg || take_best;
        max_found_next   = max_found_reg || take_max;

        if (cmd.accept)
        begin
            arrivals_next = arrivals_reg + JOB_W'(1);
            total_next    = total_reg + TIME_W'(in_data.duration);
        end
        if (cmd.fill)
            filled_next = filled_reg + CW'(1);

        if (cmd.scan_start)
        begin
            scan_active_next = 1'b1;
            rd_idx_next      = '0;
            best_found_next  = 1'b0;
            max_found_next   = 1'b0;
        end
        else if (scan_active_reg)
        begin
            if (rd_go)
                rd_idx_next = rd_idx_reg + CW'(1);
            else
                scan_active_next = 1'b0;
        end

        if (cmd.mark_done)
        begin
            done_next[best_idx_reg] = 1'b1;
            drain_cnt_next          = drain_cnt_reg + CW'(1);
        end

        if (cmd.clear)
        begin
            filled_next    = '0;
            drain_cnt_next = '0;
            arrivals_next  = '0;
            total_next     = '0;
            done_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servers_reg     <= CFG_RESET;
            filled_reg      <= '0;
            drain_cnt_reg   <= '0;
            arrivals_reg    <= '0;
            total_reg       <= '0;
            done_reg        <= '0;
            scan_active_reg <= 1'b0;
            rd_idx_reg      <= '0;
            pend_vld_reg    <= 1'b0;
            best_found_reg  <= 1'b0;
            max_found_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                servers_reg <= cfg_data;
            filled_reg      <= filled_next;
            drain_cnt_reg   <= drain_cnt_next;
            arrivals_reg    <= arrivals_next;
            total_reg       <= total_next;
            done_reg        <= done_next;
            scan_active_reg <= scan_active_next;
            rd_idx_reg      <= rd_idx_next;
            pend_vld_reg    <= pend_vld_next;
            best_found_reg  <= best_found_next;
            max_found_reg   <= max_found_next;
            if (cmd.emit_dep || cmd.emit_sum)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= rd_idx_reg[AW-1:0];
        if (cmd.accept)
            dur_reg <= in_data.duration;
        if (take_best)
        begin
            best_ft_reg  <= ft_rdata;
            best_occ_reg <= occ_rdata;
            best_idx_reg <= pend_addr_reg;
        end
        if (take_max)
        begin
            max_ft_reg  <= ft_rdata;
            max_idx_reg <= pend_addr_reg;
        end
        if (cmd.emit_dep)
        begin
            out_data_reg.kind           <= KIND_DEPART;
            out_data_reg.job_number     <= best_occ_reg;
            out_data_reg.total_duration <= '0;
            out_data_reg.latest_server  <= '0;
            out_data_reg.end_of_run     <= cmd.end_of_run;
        end
        else if (cmd.emit_sum)
        begin
            out_data_reg.kind           <= KIND_SUMMARY;
            out_data_reg.job_number     <= '0;
            out_data_reg.total_duration <= total_reg;
            out_data_reg.latest_server  <= SRV_W'(max_idx_reg) + SRV_W'(1);
            out_data_reg.end_of_run     <= cmd.end_of_run;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= CW'(SERVERS))
        else $error("occupied count beyond server count");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_dep || cmd.emit_sum) |-> out_free)
        else $error("result issued over a held item");

    a_fill_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |-> (filled_reg < n_eff) && !scan_active_reg)
        else $error("fill without a free server");

    a_drain_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark_done |-> best_found_reg && !done_reg[best_idx_reg])
        else $error("drain picked a server already emitted");

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (filled_reg == '0) && (done_reg == '0))
        else $error("batch not cleared");

endmodule

`default_nettype wire

FILE: rtl/earliest_free_server_scheduler.sv
// ----------------------------------------------------------------------------
// earliest_free_server_scheduler
// Assigns each job to the server with the earliest finish time and reports
// departures; the final job of a batch drains all servers and closes with a
// summary item.
//
//   channel  direction  payload     handshake
//   cfg      in         cfg_data    cfg_valid / cfg_ready (always ready)
//   in       in         job_t       in_valid / in_ready
//   out      out        result_t    out_valid / out_ready
//
// A job that fills an empty server is written without a scan. A job that
// replaces an occupant waits for a sweep over the F occupied servers: one RAM
// read port sweeps the finish times, one compare per cycle. A final job adds
// F drain sweeps over the same servers, then the summary item.
// Reset empties the batch at once; no clearing pass. A stalled out channel
// holds the sequencer while the next result is waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module earliest_free_server_scheduler
    import efs_pkg::*;
#(
    parameter int SERVERS = SERVERS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire job_t             in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output result_t               out_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    efs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .final_job (in_data.final_job),
        .in_ready  (in_ready),
        .status    (status),
        .cmd       (cmd)
    );

    efs_dp #(
        .SERVERS (SERVERS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
